FILE: hdl/lpfi_pkg.sv
// shared widths, codes and reset values of the led peak fade indicator
`default_nettype none

package lpfi_pkg;

    localparam int VelW    = 16;
    localparam int LevelW  = 16;
    localparam int DutyW   = 8;
    localparam int CfgW    = 16;
    localparam int CfgIdxW = 1;

    // item commands
    localparam logic CmdTick = 1'b0;
    localparam logic CmdHit  = 1'b1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgInterval = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgDecay    = 1'b1;

    localparam logic [CfgW-1:0] IntervalRst = 16'd10;
    localparam logic [CfgW-1:0] DecayRst    = 16'd58657;

endpackage

`default_nettype wire

FILE: hdl/lpfi_in_if.sv
// input channel: tick or hit items
`default_nettype none

interface lpfi_in_if;
    import lpfi_pkg::*;

    logic            valid;
    logic            ready;
    logic            cmd;
    logic [VelW-1:0] velocity;

    modport source (output valid, output cmd, output velocity, input ready);
    modport sink   (input valid, input cmd, input velocity, output ready);
endinterface

`default_nettype wire

FILE: hdl/lpfi_out_if.sv
// output channel: duty and lit items
`default_nettype none

interface lpfi_out_if;
    import lpfi_pkg::*;

    logic             valid;
    logic             ready;
    logic [DutyW-1:0] duty;
    logic             lit;

    modport source (output valid, output duty, output lit, input ready);
    modport sink   (input valid, input duty, input lit, output ready);
endinterface

`default_nettype wire

FILE: hdl/lpfi_sqrt.sv
// iterative square root of velocity times 65536, one root bit per cycle
`default_nettype none

module lpfi_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpfi_pkg::VelW-1:0]  i_velocity,
    output logic                       o_done,
    output logic [lpfi_pkg::LevelW-1:0] o_root
);
    import lpfi_pkg::*;

    localparam int RadW  = 2 * VelW;
    localparam int RemW  = LevelW + 1;
    localparam int CntW  = $clog2(LevelW);
    localparam logic [CntW-1:0] LastStep = CntW'(LevelW - 1);

    logic [RadW-1:0]   r_rad;
    logic [RemW-1:0]   r_rem;
    logic [LevelW-1:0] r_root;
    logic [CntW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [RemW+1:0] rem_sh;
    logic [RemW+1:0] trial;
    logic            fits;

    always_comb begin
        rem_sh = {r_rem, r_rad[RadW-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {i_velocity, {(RadW-VelW){1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RadW-3:0], 2'b00};
            if (fits) begin
                r_rem  <= RemW'(rem_sh - trial);
                r_root <= {r_root[LevelW-2:0], 1'b1};
            end else begin
                r_rem  <= RemW'(rem_sh);
                r_root <= {r_root[LevelW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: hdl/led_peak_fade_indicator.sv
// led peak fade indicator: pwm duty for a flash on hit and exponential fade on ticks
// sequence: a tick item passes S_SCALE and S_SHOW, with S_DECAY and S_LOAD first for a fade step
// sequence: a hit item waits in S_ROOT for the 16 steps of the bit-serial square root
// throughput: one item at a time; the next item is taken once the result sits in the
//   output register, which waits while a pending result has not yet been taken
// reset: synchronous active low; level and tick count clear, config registers take their defaults
`default_nettype none

module led_peak_fade_indicator #(
    parameter int PWM_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lpfi_in_if.sink                      i_item,
    lpfi_out_if.source                   o_result,
    input  logic                         i_cfg_we,
    input  logic [lpfi_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [lpfi_pkg::CfgW-1:0]    i_cfg_wdata
);
    import lpfi_pkg::*;

    localparam int ProdW = 2 * LevelW;
    localparam logic [LevelW-1:0] PwmMax = LevelW'((1 << PWM_BITS) - 1);
    localparam logic [ProdW-1:0]  ThrLimit =
        {{(LevelW-1){1'b0}}, 1'b1, {LevelW{1'b0}}};

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROOT  = 6'b000010,
        S_DECAY = 6'b000100,
        S_LOAD  = 6'b001000,
        S_SCALE = 6'b010000,
        S_SHOW  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CfgW-1:0]    r_interval;
    logic [CfgW-1:0]    r_decay;
    logic [LevelW-1:0]  r_level, n_level;
    logic [LevelW-1:0]  r_elapsed, n_elapsed;
    logic               r_thr, n_thr;
    logic [ProdW-1:0]   r_prod;
    logic               r_out_valid, n_out_valid;
    logic [DutyW-1:0]   r_duty, n_duty;
    logic               r_lit, n_lit;

    logic               accept;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [LevelW-1:0]  sqrt_root;
    logic [LevelW-1:0]  elapsed_inc;
    logic               fade;
    logic [LevelW-1:0]  mul_b;
    logic               slot_free;
    logic               show_load;
    logic               to_dark;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign sqrt_start   = accept && (i_item.cmd == CmdHit);

    lpfi_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_velocity (i_item.velocity),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // saturating tick count and fade decision
    always_comb begin
        elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + LevelW'(1);
        fade        = (r_level != '0) && (elapsed_inc >= r_interval);
    end

    // shared multiplier: decay factor during a fade step, pwm scale otherwise
    assign mul_b = (r_state == S_DECAY) ? r_decay : PwmMax;

    always_ff @(posedge i_clk) begin
        r_prod <= ProdW'(r_level) * ProdW'(mul_b);
    end

    assign slot_free = !r_out_valid || o_result.ready;
    assign show_load = (r_state == S_SHOW) && slot_free;
    assign to_dark   = r_thr && (r_prod <= ThrLimit);

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_elapsed   = r_elapsed;
        n_thr       = r_thr;
        n_out_valid = r_out_valid;
        n_duty      = r_duty;
        n_lit       = r_lit;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_thr = 1'b0;
                    if (i_item.cmd == CmdHit) begin
                        n_elapsed = '0;
                        n_state   = S_ROOT;
                    end else if (fade) begin
                        n_elapsed = '0;
                        n_state   = S_DECAY;
                    end else begin
                        n_elapsed = elapsed_inc;
                        n_state   = S_SCALE;
                    end
                end
            end
            S_ROOT: begin
                if (sqrt_done) begin
                    n_level = sqrt_root;
                    n_state = S_SCALE;
                end
            end
            S_DECAY: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_level = r_prod[ProdW-1 -: LevelW];
                n_thr   = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (to_dark) begin
                        n_level = '0;
                        n_duty  = '0;
                        n_lit   = 1'b0;
                    end else begin
                        n_duty = r_prod[LevelW +: DutyW];
                        n_lit  = (r_level != '0);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_elapsed   <= '0;
            r_thr       <= 1'b0;
            r_out_valid <= 1'b0;
            r_interval  <= IntervalRst;
            r_decay     <= DecayRst;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_elapsed   <= n_elapsed;
            r_thr       <= n_thr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgInterval: r_interval <= i_cfg_wdata;
                    CfgDecay:    r_decay    <= i_cfg_wdata;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_duty <= n_duty;
        r_lit  <= n_lit;
    end

    assign o_result.valid = r_out_valid;
    assign o_result.duty  = r_duty;
    assign o_result.lit   = r_lit;

    // the lit flag always matches the level left behind by the item
    a_lit_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        show_load |=> (r_lit == (r_level != '0)))
        else $error("lit flag disagrees with stored level");

    // the root unit only finishes while the sequencer waits for it
    a_root_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == S_ROOT))
        else $error("square root finished outside its wait state");

    // no second item is taken right behind an accepted one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_item.ready)
        else $error("input ready right after an accepted item");

    // a result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> r_out_valid && $stable(r_duty))
        else $error("pending result lost");

endmodule

`default_nettype wire
